>>> hw/rtl/ttc_pkg.sv
// shared widths, reciprocal constants and calendar tables for the timestamp converter
package ttc_pkg;

  localparam int unsigned TS_W     = 32;
  localparam int unsigned TZ_W     = 5;
  localparam int unsigned DAYS_W   = 16;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DOM_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;

  localparam int unsigned SECS_W   = 17;  // seconds within a day
  localparam int unsigned REMH_W   = 12;  // seconds within an hour
  localparam int unsigned CYC_W    = 6;   // four-year cycles
  localparam int unsigned REM_W    = 11;  // day within a four-year period
  localparam int unsigned DOY_W    = 9;   // day within a year

  localparam logic [11:0] SEC_PER_HOUR   = 12'd3600;
  localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
  localparam logic [5:0]  SEC_PER_MIN    = 6'd60;
  localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;

  // floor(x / 675) for x < 2^25, used on seconds >> 7
  localparam logic [25:0] RECIP_DAY   = 26'd50903317;
  localparam int unsigned SHIFT_DAY   = 35;
  // floor(x / 1461) for x < 2^16
  localparam logic [16:0] RECIP_CYC   = 17'd91868;
  localparam int unsigned SHIFT_CYC   = 27;
  // floor(x / 225) for x < 5400, used on seconds >> 4
  localparam logic [13:0] RECIP_HOUR  = 14'd9321;
  localparam int unsigned SHIFT_HOUR  = 21;
  // floor(x / 15) for x < 900, used on seconds >> 2
  localparam logic [10:0] RECIP_MIN   = 11'd1093;
  localparam int unsigned SHIFT_MIN   = 14;

  localparam logic [REM_W-1:0] YEAR1_START = 11'd365;
  localparam logic [REM_W-1:0] YEAR2_START = 11'd730;
  localparam logic [REM_W-1:0] YEAR3_START = 11'd1096;
  localparam logic [1:0]       LEAP_SLOT   = 2'd2;

  // first day of a month within the year, month index from 0
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

>>> hw/rtl/ttc_if.sv
// handshake channels for the timestamp converter
interface ttc_in_if;
  import ttc_pkg::*;
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] timestamp;
  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

interface ttc_out_if;
  import ttc_pkg::*;
  logic               valid;
  logic               ready;
  logic [DAYS_W-1:0]  day_count;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DOM_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  modport source (output valid, output day_count, output year, output month,
                  output day_of_month, output hour, output minute, output second,
                  input ready);
  modport sink   (input valid, input day_count, input year, input month,
                  input day_of_month, input hour, input minute, input second,
                  output ready);
endinterface

interface ttc_cfg_if;
  import ttc_pkg::*;
  logic            valid;
  logic            ready;
  logic [TZ_W-1:0] time_zone_hours;
  modport source (output valid, output time_zone_hours, input ready);
  modport sink   (input valid, input time_zone_hours, output ready);
endinterface

>>> hw/rtl/timestamp_to_calendar.sv
// seconds-since-1970 timestamp to calendar date and time of day
//
//   channel   dir  word
//   in_chan   in   timestamp
//   out_chan  out  day_count, year, month, day_of_month, hour, minute, second
//   cfg_chan  in   time_zone_hours
//
// seven register stages, one word accepted per cycle while the pipeline is not held
// the stage count is set by the chain of reciprocal multiplies and their remainders
// the whole pipeline holds while the last stage is full and out_chan.ready is low
// rst_n clears the stage valid bits and the zone offset; cfg_chan is always ready
module timestamp_to_calendar
  import ttc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ttc_in_if.sink    in_chan,
  ttc_cfg_if.sink   cfg_chan,
  ttc_out_if.source out_chan
);

  logic [6:0]        vld_r;
  logic              adv;
  logic [TZ_W-1:0]   tz_r;

  logic [TS_W-1:0]   ts1_r, ts2_r;
  logic [DAYS_W-1:0] days2_r, days3_r, days4_r, days5_r, days6_r, days7_r;
  logic [CYC_W-1:0]  cyc3_r, cyc4_r;
  logic [SECS_W-1:0] secs3_r, secs4_r;
  logic [REM_W-1:0]  rem4_r;
  logic [HOUR_W-1:0] hour4_r, hour5_r, hour6_r, hour7_r;
  logic [DOY_W-1:0]  doy5_r;
  logic              leap5_r;
  logic [YEAR_W-1:0] year5_r, year6_r, year7_r;
  logic [REMH_W-1:0] remh5_r, remh6_r;
  logic [MONTH_W-1:0] month6_r, month7_r;
  logic [DOM_W-1:0]  dom6_r, dom7_r;
  logic [MIN_W-1:0]  min6_r, min7_r;
  logic [SEC_W-1:0]  sec7_r;

  logic [TS_W-1:0]   ts1_nxt;
  logic [50:0]       day_prod;
  logic [32:0]       cyc_prod;
  logic [32:0]       daysec_prod;
  logic [SECS_W-1:0] secs3_nxt;
  logic [16:0]       cycday_prod;
  logic [26:0]       hour_prod;
  logic [REM_W-1:0]  rem4_nxt;
  logic [1:0]        yslot;
  logic [REM_W-1:0]  ystart;
  logic [YEAR_W-1:0] year5_nxt;
  logic [16:0]       hoursec_prod;
  logic [REMH_W-1:0] remh5_nxt;
  logic [MONTH_W-1:0] midx;
  logic [DOY_W-1:0]  dom_off;
  logic [20:0]       min_prod;
  logic [11:0]       minsec_prod;
  logic [SEC_W-1:0]  sec7_nxt;

  assign adv           = !vld_r[6] || out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  // offset add, wrapping at 32 bits
  assign ts1_nxt = in_chan.timestamp + TS_W'(tz_r) * TS_W'(SEC_PER_HOUR);

  // days = ts / 86400
  assign day_prod = 51'(ts1_r[TS_W-1:7]) * 51'(RECIP_DAY);

  // cycles = days / 1461, seconds of day = ts - days * 86400
  assign cyc_prod    = 33'(days2_r) * 33'(RECIP_CYC);
  assign daysec_prod = 33'(days2_r) * 33'(SEC_PER_DAY);
  assign secs3_nxt   = ts2_r[SECS_W-1:0] - daysec_prod[SECS_W-1:0];

  // day within cycle, hour = secs / 3600
  assign cycday_prod = 17'(cyc3_r) * 17'(DAYS_PER_CYCLE);
  assign rem4_nxt    = days3_r[REM_W-1:0] - cycday_prod[REM_W-1:0];
  assign hour_prod   = 27'(secs3_r[SECS_W-1:4]) * 27'(RECIP_HOUR);

  // year slot within the cycle, seconds within the hour
  always_comb begin
    if (rem4_r >= YEAR3_START) begin
      yslot  = 2'd3;
      ystart = YEAR3_START;
    end else if (rem4_r >= YEAR2_START) begin
      yslot  = 2'd2;
      ystart = YEAR2_START;
    end else if (rem4_r >= YEAR1_START) begin
      yslot  = 2'd1;
      ystart = YEAR1_START;
    end else begin
      yslot  = 2'd0;
      ystart = '0;
    end
  end
  assign year5_nxt    = BASE_YEAR + YEAR_W'({cyc4_r, 2'b00}) + YEAR_W'(yslot);
  assign hoursec_prod = 17'(hour4_r) * 17'(SEC_PER_HOUR);
  assign remh5_nxt    = secs4_r[REMH_W-1:0] - hoursec_prod[REMH_W-1:0];

  // month by parallel compares against month starts, minute = remh / 60
  always_comb begin
    midx = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy5_r >= month_start(MONTH_W'(i), leap5_r)) begin
        midx = MONTH_W'(i);
      end
    end
  end
  assign dom_off  = doy5_r - month_start(midx, leap5_r);
  assign min_prod = 21'(remh5_r[REMH_W-1:2]) * 21'(RECIP_MIN);

  // second = remh - minute * 60
  assign minsec_prod = 12'(min6_r) * 12'(SEC_PER_MIN);
  assign sec7_nxt    = remh6_r[SEC_W-1:0] - minsec_prod[SEC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      tz_r  <= '0;
    end else begin
      if (cfg_chan.valid) begin
        tz_r <= cfg_chan.time_zone_hours;
      end
      if (adv) begin
        vld_r <= {vld_r[5:0], in_chan.valid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ts1_r    <= ts1_nxt;

      ts2_r    <= ts1_r;
      days2_r  <= day_prod[SHIFT_DAY +: DAYS_W];

      days3_r  <= days2_r;
      cyc3_r   <= cyc_prod[SHIFT_CYC +: CYC_W];
      secs3_r  <= secs3_nxt;

      days4_r  <= days3_r;
      cyc4_r   <= cyc3_r;
      secs4_r  <= secs3_r;
      rem4_r   <= rem4_nxt;
      hour4_r  <= hour_prod[SHIFT_HOUR +: HOUR_W];

      days5_r  <= days4_r;
      hour5_r  <= hour4_r;
      doy5_r   <= DOY_W'(rem4_r - ystart);
      leap5_r  <= (yslot == LEAP_SLOT);
      year5_r  <= year5_nxt;
      remh5_r  <= remh5_nxt;

      days6_r  <= days5_r;
      hour6_r  <= hour5_r;
      year6_r  <= year5_r;
      remh6_r  <= remh5_r;
      month6_r <= midx + MONTH_W'(1);
      dom6_r   <= DOM_W'(dom_off) + DOM_W'(1);
      min6_r   <= min_prod[SHIFT_MIN +: MIN_W];

      days7_r  <= days6_r;
      hour7_r  <= hour6_r;
      year7_r  <= year6_r;
      month7_r <= month6_r;
      dom7_r   <= dom6_r;
      min7_r   <= min6_r;
      sec7_r   <= sec7_nxt;
    end
  end

  assign out_chan.valid        = vld_r[6];
  assign out_chan.day_count    = days7_r;
  assign out_chan.year         = year7_r;
  assign out_chan.month        = month7_r;
  assign out_chan.day_of_month = dom7_r;
  assign out_chan.hour         = hour7_r;
  assign out_chan.minute       = min7_r;
  assign out_chan.second       = sec7_r;

endmodule
